>>> design/lrc_pkg.sv
// Shared constants, codes and types of the looped cubic table reader.
`default_nettype none
package lrc_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = 12;
  localparam int LEN_W       = 13;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int GUARD_BITS  = 8;
  localparam int POS_W       = 32;
  localparam int LOOP_END_W  = 13;
  localparam int DIV_W       = 34;
  localparam int DIV_CNT_W   = 6;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_PLAY  = 1'b1;

  localparam logic REG_ABS_MODE     = 1'b0;
  localparam logic REG_TABLE_LENGTH = 1'b1;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> design/lrc_if.sv
// Item channels: input items and result samples.
`default_nettype none
interface lrc_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   func;
  logic [lrc_pkg::ADDR_W-1:0]             table_index;
  logic signed [lrc_pkg::SAMPLE_BITS-1:0] sample_value;
  logic signed [lrc_pkg::POS_W-1:0]       position;
  logic [lrc_pkg::ADDR_W-1:0]             loop_start;
  logic signed [lrc_pkg::LOOP_END_W-1:0]  loop_end;
  modport source (output valid, func, table_index, sample_value, position, loop_start,
                  loop_end, input ready);
  modport sink (input valid, func, table_index, sample_value, position, loop_start,
                loop_end, output ready);
endinterface

interface lrc_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [lrc_pkg::SAMPLE_BITS-1:0] sample_out;
  modport source (output valid, sample_out, input ready);
  modport sink (input valid, sample_out, output ready);
endinterface
`default_nettype wire

>>> design/lrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lrc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

>>> design/lrc_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module lrc_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lrc_pkg::div_req_t req_i,
  output lrc_pkg::div_rsp_t      rsp_o
);
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [lrc_pkg::DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [lrc_pkg::DIV_W-1:0]      rem_q, rem_d;
  logic [lrc_pkg::DIV_W-1:0]      quo_q, quo_d;
  logic [lrc_pkg::DIV_W-1:0]      den_q, den_d;
  logic [lrc_pkg::DIV_W:0]        trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    trial  = {rem_q, quo_q[lrc_pkg::DIV_W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = lrc_pkg::DIV_CNT_W'(lrc_pkg::DIV_W);
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = lrc_pkg::DIV_W'(trial - {1'b0, den_q});
        quo_d = {quo_q[lrc_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial[lrc_pkg::DIV_W-1:0];
        quo_d = {quo_q[lrc_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == lrc_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;
endmodule
`default_nettype wire

>>> design/looped_table_reader_cubic.sv
// Top level: looped table player with Catmull-Rom interpolation and smoothing.
//
//  channel  | direction | beat contents
//  ---------+-----------+----------------------------------------------------
//  in_i     | in        | func, table_index, sample_value, position, loops
//  out_o    | out       | sample_out, one beat per play item
//  apb      | in        | mode flag (absolute folding) at 0x0, table_length at 0x4
//
// A write item is written to the table when accepted. A play item for a table shorter
// than four outputs a zero sample without division; else it runs up to three passes
// of the shared 34-step divider (position folding, loop
// wrapping, smoothing division), the table reads of four neighbouring samples and three
// multiply-accumulate steps. Reset clears the registers and the smoothing state;
// the table holds no reset. in_i is not ready while a play item is at work; a
// waiting result on out_o stalls only the end of the following play item.
`default_nettype none
module looped_table_reader_cubic (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  lrc_in_if.sink                           in_i,
  lrc_out_if.source                        out_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lrc_pkg::APB_AW-1:0]  paddr,
  input  wire logic [lrc_pkg::APB_DW-1:0]  pwdata,
  output logic      [lrc_pkg::APB_DW-1:0]  prdata,
  output logic                             pready
);
  localparam int W  = lrc_pkg::DIV_W;
  localparam int SB = lrc_pkg::SAMPLE_BITS;
  localparam int FB = lrc_pkg::FRAC_BITS;
  localparam int AW = lrc_pkg::ADDR_W;
  localparam int LW = lrc_pkg::LEN_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FOLD = 4'd1;
  localparam logic [3:0] S_WRAP = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_PREP = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_ACC  = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_SDIV = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  localparam logic signed [31:0] SAT_HI = 32'sd32767;
  localparam logic signed [31:0] SAT_LO = -32'sd32768;

  // configuration
  logic          abs_q;
  logic [LW-1:0] tlen_q;
  logic          cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_q  <= 1'b0;
      tlen_q <= '0;
    end else if (cfg_we) begin
      unique case (paddr[2])
        lrc_pkg::REG_ABS_MODE:     abs_q  <= pwdata[0];
        lrc_pkg::REG_TABLE_LENGTH: tlen_q <= pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      lrc_pkg::REG_ABS_MODE:     prdata = {31'b0, abs_q};
      lrc_pkg::REG_TABLE_LENGTH: prdata = {{(32-LW){1'b0}}, tlen_q};
      default:                   prdata = '0;
    endcase
  end

  // state
  logic [3:0]              st_q, st_d;
  logic [LW-1:0]           len_q, len_d;
  logic [AW-1:0]           s_q, s_d;
  logic [AW-1:0]           e_q, e_d;
  logic signed [31:0]      prev_pos_q, prev_pos_d;
  logic signed [SB-1:0]    prev_out_q, prev_out_d;
  logic [32:0]             diff_q, diff_d;
  logic [W-1:0]            base_q, base_d;
  logic [W-1:0]            mod_q, mod_d;
  logic                    neg_q, neg_d;
  logic [27:0]             wp_q, wp_d;
  logic [2:0]              rd_q, rd_d;
  logic signed [SB-1:0]    smp_q [4];
  logic signed [SB-1:0]    smp_d [4];
  logic signed [31:0]      h_q, h_d;
  logic signed [48:0]      prod_q, prod_d;
  logic [1:0]              step_q, step_d;
  logic signed [SB-1:0]    y_q, y_d;
  logic                    ov_q, ov_d;
  logic signed [SB-1:0]    od_q, od_d;

  lrc_pkg::div_req_t div_req;
  lrc_pkg::div_rsp_t div_rsp;

  lrc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [SB-1:0] ram_rdata;

  lrc_ram #(.WIDTH(SB), .DEPTH(lrc_pkg::TABLE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_i.table_index),
    .wdata_i (in_i.sample_value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // combinational helpers
  logic [LW-1:0]      len_in, s_in, e_in, lm1_in, lm1;
  logic signed [W-1:0] pos_x, x_v;
  logic [W-1:0]       lq, sq, eq, fm, ap, rv, ll_in;
  logic [AW-1:0]      i1;
  logic [LW:0]        i1p1, i1p2;
  logic [15:0]        t;
  logic signed [31:0] sa, sb_, sc, sd;
  logic signed [31:0] p1, p2, p3, addv, yv;
  logic signed [16:0] dy;
  logic signed [17:0] ys;
  logic [16:0]        qm;

  always_comb begin
    len_in = (tlen_q > LW'(lrc_pkg::TABLE_DEPTH)) ? LW'(lrc_pkg::TABLE_DEPTH) : tlen_q;
    lm1_in = len_in - 1'b1;
    s_in   = ({1'b0, in_i.loop_start} > lm1_in) ? lm1_in : {1'b0, in_i.loop_start};
    e_in   = (in_i.loop_end[LW-1] || in_i.loop_end[LW-2:0] > lm1_in[LW-2:0]
              || lm1_in[LW-1]) ? lm1_in : {1'b0, in_i.loop_end[LW-2:0]};
    if (in_i.loop_end[LW-1]) e_in = lm1_in;
    ll_in  = (e_in >= s_in) ? W'(e_in - s_in + 1'b1)
                            : W'(len_in - s_in + e_in + 1'b1);
    pos_x  = W'(in_i.position);
    lm1    = len_q - 1'b1;
    lq     = W'(len_q) << FB;
    sq     = W'(s_q) << FB;
    eq     = W'(e_q) << FB;
    fm     = (neg_q && div_rsp.rem != '0) ? mod_q - div_rsp.rem : div_rsp.rem;
    ap     = fm;
    rv     = base_q + fm;
    if (rv >= lq) rv = rv - lq;
    i1     = wp_q[27:FB];
    i1p1   = {2'b0, i1} + 1'b1;
    i1p2   = {2'b0, i1} + 2'd2;
    if (i1p1 >= {1'b0, len_q}) i1p1 = i1p1 - {1'b0, len_q};
    if (i1p2 >= {1'b0, len_q}) i1p2 = i1p2 - {1'b0, len_q};
    t      = wp_q[FB-1:0];
    sa     = 32'(smp_q[0]);
    sb_    = 32'(smp_q[1]);
    sc     = 32'(smp_q[2]);
    sd     = 32'(smp_q[3]);
    p1     = sc - sa;
    p2     = 2 * sa - 5 * sb_ + 4 * sc - sd;
    p3     = 3 * sb_ - 3 * sc + sd - sa;
    addv   = 32'(prod_q >>> FB);
    yv     = sb_ + ((h_q + (32'sd1 <<< lrc_pkg::GUARD_BITS)) >>> (lrc_pkg::GUARD_BITS + 1));
    dy     = 17'(y_q) - 17'(prev_out_q);
    qm     = div_rsp.quo[16:0];
    ys     = neg_q ? 18'(prev_out_q) - 18'($signed({1'b0, qm}))
                   : 18'(prev_out_q) + 18'($signed({1'b0, qm}));
  end

  always_comb begin
    unique case (rd_q)
      3'd0:    ram_raddr = (i1 == '0) ? lm1[AW-1:0] : i1 - 1'b1;
      3'd1:    ram_raddr = i1;
      3'd2:    ram_raddr = i1p1[AW-1:0];
      default: ram_raddr = i1p2[AW-1:0];
    endcase
  end

  assign in_i.ready   = (st_q == S_IDLE);
  assign ram_we       = in_i.valid && in_i.ready && (in_i.func == lrc_pkg::FUNC_WRITE);
  assign out_o.valid  = ov_q;
  assign out_o.sample_out = od_q;

  always_comb begin
    st_d       = st_q;
    len_d      = len_q;
    s_d        = s_q;
    e_d        = e_q;
    prev_pos_d = prev_pos_q;
    prev_out_d = prev_out_q;
    diff_d     = diff_q;
    base_d     = base_q;
    mod_d      = mod_q;
    neg_d      = neg_q;
    wp_d       = wp_q;
    rd_d       = rd_q;
    smp_d      = smp_q;
    h_d        = h_q;
    prod_d     = prod_q;
    step_d     = step_q;
    y_d        = y_q;
    ov_d       = ov_q && !out_o.ready;
    od_d       = od_q;
    div_req    = '0;
    x_v        = '0;
    unique case (st_q)
      S_IDLE: begin
        if (in_i.valid && in_i.func == lrc_pkg::FUNC_PLAY) begin
          len_d = len_in;
          s_d   = s_in[AW-1:0];
          e_d   = e_in[AW-1:0];
          if (len_in < LW'(4)) begin
            prev_pos_d = '0;
            prev_out_d = '0;
            y_d        = '0;
            diff_d     = '0;
            st_d       = S_DONE;
          end else begin
            diff_d     = (in_i.position >= prev_pos_q)
                         ? 33'(33'(in_i.position) - 33'(prev_pos_q))
                         : 33'(33'(prev_pos_q) - 33'(in_i.position));
            prev_pos_d = in_i.position;
            neg_d      = in_i.position[31];
            div_req.start = 1'b1;
            div_req.num   = in_i.position[31] ? W'(-pos_x) : W'(pos_x);
            if (abs_q) begin
              div_req.den = W'(len_in) << FB;
              st_d        = S_FOLD;
            end else begin
              div_req.den = ll_in << FB;
              base_d      = W'(s_in) << FB;
              st_d        = S_WRAP;
            end
            mod_d = div_req.den;
          end
        end
      end
      S_FOLD: begin
        if (div_rsp.done) begin
          rd_d = '0;
          if (s_q == e_q) begin
            wp_d = sq[27:0];
            st_d = S_RD;
          end else if (s_q < e_q) begin
            if (ap >= sq && ap <= eq) begin
              wp_d = ap[27:0];
              st_d = S_RD;
            end else begin
              x_v           = $signed(ap) - $signed(sq);
              div_req.den   = W'(e_q - s_q + 1'b1) << FB;
              st_d          = S_WRAP;
            end
          end else begin
            if (ap >= sq || ap <= eq) begin
              wp_d = ap[27:0];
              st_d = S_RD;
            end else begin
              x_v           = $signed(ap) - $signed(W'(e_q + 1'b1) << FB);
              div_req.den   = W'(len_q - s_q + e_q + 1'b1) << FB;
              st_d          = S_WRAP;
            end
          end
          if (st_d == S_WRAP) begin
            div_req.start = 1'b1;
            div_req.num   = x_v[W-1] ? W'(-x_v) : W'(x_v);
            neg_d         = x_v[W-1];
            mod_d         = div_req.den;
            base_d        = sq;
          end
        end
      end
      S_WRAP: begin
        if (div_rsp.done) begin
          wp_d = rv[27:0];
          rd_d = '0;
          st_d = S_RD;
        end
      end
      S_RD: begin
        // issue one address a cycle, take the data in the next cycle
        if (rd_q != 3'd0) smp_d[rd_q[1:0] - 1'b1] = ram_rdata;
        rd_d = rd_q + 1'b1;
        if (rd_q == 3'd4) st_d = S_PREP;
      end
      S_PREP: begin
        h_d    = p3 <<< lrc_pkg::GUARD_BITS;
        step_d = '0;
        st_d   = S_MUL;
      end
      S_MUL: begin
        prod_d = h_q * $signed({1'b0, t});
        st_d   = S_ACC;
      end
      S_ACC: begin
        case (step_q)
          2'd0:    h_d = (p2 <<< lrc_pkg::GUARD_BITS) + addv;
          2'd1:    h_d = (p1 <<< lrc_pkg::GUARD_BITS) + addv;
          default: h_d = addv;
        endcase
        step_d = step_q + 1'b1;
        st_d   = (step_q == 2'd2) ? S_FIN : S_MUL;
      end
      S_FIN: begin
        y_d  = (yv > SAT_HI) ? SB'(SAT_HI) : ((yv < SAT_LO) ? SB'(SAT_LO) : yv[SB-1:0]);
        st_d = S_DONE;
        if (diff_q > 33'(1 << FB)) begin
          st_d = S_SDIV;
        end
      end
      S_SDIV: begin
        if (!neg_q && mod_q == '0) begin
          // launch the smoothing division once, then wait for its result
          neg_d         = dy[16];
          mod_d         = '1;
          div_req.start = 1'b1;
          div_req.num   = dy[16] ? W'(-dy) << FB : W'(dy) << FB;
          div_req.den   = W'(diff_q);
        end else if (div_rsp.done) begin
          y_d  = ys[SB-1:0];
          st_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_q || out_o.ready) begin
          ov_d       = 1'b1;
          od_d       = y_q;
          prev_out_d = y_q;
          st_d       = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
    // clear the launch marker before the smoothing division
    if (st_q == S_FIN && st_d == S_SDIV) begin
      neg_d = 1'b0;
      mod_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_IDLE;
      prev_pos_q <= '0;
      prev_out_q <= '0;
      ov_q       <= 1'b0;
      rd_q       <= '0;
      step_q     <= '0;
    end else begin
      st_q       <= st_d;
      prev_pos_q <= prev_pos_d;
      prev_out_q <= prev_out_d;
      ov_q       <= ov_d;
      rd_q       <= rd_d;
      step_q     <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    s_q    <= s_d;
    e_q    <= e_d;
    diff_q <= diff_d;
    base_q <= base_d;
    mod_q  <= mod_d;
    neg_q  <= neg_d;
    wp_q   <= wp_d;
    smp_q  <= smp_d;
    h_q    <= h_d;
    prod_q <= prod_d;
    y_q    <= y_d;
    od_q   <= od_d;
  end
endmodule
`default_nettype wire
